// ----- sv/p2acg_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// p2acg_pkg
// Shared types and constants of the pixel to ANSI colour glyph encoder.
// ----------------------------------------------------------------------------
package p2acg_pkg;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       row_end;
    logic       image_end;
  } pixel_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } result_t;

  typedef struct packed {
    logic [1:0] h;
    logic [3:0] t;
    logic [3:0] o;
  } digits_t;

  typedef struct packed {
    digits_t    r;
    digits_t    g;
    digits_t    b;
    logic [7:0] glyph;
    logic       row_end;
    logic       image_end;
  } cmd_t;

  localparam int unsigned SumW = 22;

  typedef struct packed {
    logic [SumW-1:0] sum;
    logic [1:0]      hr;
    logic [6:0]      rr;
    logic [1:0]      hg;
    logic [6:0]      rg;
    logic [1:0]      hb;
    logic [6:0]      rb;
    logic            row_end;
    logic            image_end;
  } lum_stage_t;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = $clog2(QDepth);

  localparam logic [12:0] WRed   = 13'd2126;
  localparam logic [12:0] WGreen = 13'd7152;
  localparam logic [12:0] WBlue  = 13'd722;

  // Weighted sum at which luminance first exceeds each band top
  localparam logic [SumW-1:0] BandStep [9] = '{
    SumW'(26 * 10000), SumW'(52 * 10000), SumW'(77 * 10000),
    SumW'(103 * 10000), SumW'(128 * 10000), SumW'(154 * 10000),
    SumW'(179 * 10000), SumW'(205 * 10000), SumW'(230 * 10000)
  };

  localparam logic [7:0] RampGlyph [10] = '{
    8'h20, 8'h2E, 8'h3A, 8'h21, 8'h2B, 8'h2A, 8'h65, 8'h24, 8'h40, 8'h23
  };

  localparam logic [7:0] ChEsc   = 8'h1B;
  localparam logic [7:0] ChLbr   = 8'h5B;
  localparam logic [7:0] ChThree = 8'h33;
  localparam logic [7:0] ChEight = 8'h38;
  localparam logic [7:0] ChSemi  = 8'h3B;
  localparam logic [7:0] ChTwo   = 8'h32;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChM     = 8'h6D;
  localparam logic [7:0] ChNl    = 8'h0A;

  typedef enum logic [4:0] {
    ST_ESC, ST_LBR, ST_3, ST_8, ST_SEMI_A, ST_2, ST_SEMI_B,
    ST_RH, ST_RT, ST_RO, ST_SEMI_C,
    ST_GH, ST_GT, ST_GO, ST_SEMI_D,
    ST_BH, ST_BT, ST_BO, ST_M, ST_GLYPH, ST_NL,
    ST_X0, ST_X1, ST_X2, ST_X3
  } step_e;

endpackage
`default_nettype wire

// ----- sv/p2acg_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// p2acg_front
// Accepts pixels, computes the weighted luminance sum and the decimal digits
// of each channel over two stages, and hands a byte command to the queue.
// ----------------------------------------------------------------------------
module p2acg_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire p2acg_pkg::pixel_t in_data_i,
  output logic                   cmd_valid_o,
  input  wire logic              q_full_i,
  output p2acg_pkg::cmd_t        cmd_o
);
  import p2acg_pkg::*;

  function automatic logic [1:0] hundreds(input logic [7:0] v);
    logic [1:0] h;
    h = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
    return h;
  endfunction

  function automatic logic [6:0] below_hundred(input logic [7:0] v, input logic [1:0] h);
    logic [7:0] r;
    r = v - ((h == 2'd2) ? 8'd200 : ((h == 2'd1) ? 8'd100 : 8'd0));
    return r[6:0];
  endfunction

  function automatic digits_t split(input logic [1:0] h, input logic [6:0] rem);
    digits_t    d;
    logic [14:0] prod;
    logic [6:0]  tens10;
    logic [6:0]  ones;
    prod   = 15'(rem) * 15'd205;
    d.h    = h;
    d.t    = prod[14:11];
    tens10 = 7'(d.t) * 7'd10;
    ones   = rem - tens10;
    d.o    = ones[3:0];
    return d;
  endfunction

  logic       s1_v_q, s2_v_q;
  pixel_t     s1_q;
  lum_stage_t s2_q, s2_d;
  logic       adv1, adv2;
  logic [3:0] band;

  assign adv2       = !s2_v_q || !q_full_i;
  assign adv1       = !s1_v_q || adv2;
  assign in_stall_o = !adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      if (adv1) s1_v_q <= in_valid_i;
      if (adv2) s2_v_q <= s1_v_q;
    end
  end

  always_comb begin
    s2_d.sum = SumW'(21'(s1_q.red) * 21'(WRed))
             + SumW'(21'(s1_q.green) * 21'(WGreen))
             + SumW'(21'(s1_q.blue) * 21'(WBlue));
    s2_d.hr        = hundreds(s1_q.red);
    s2_d.rr        = below_hundred(s1_q.red, s2_d.hr);
    s2_d.hg        = hundreds(s1_q.green);
    s2_d.rg        = below_hundred(s1_q.green, s2_d.hg);
    s2_d.hb        = hundreds(s1_q.blue);
    s2_d.rb        = below_hundred(s1_q.blue, s2_d.hb);
    s2_d.row_end   = s1_q.row_end;
    s2_d.image_end = s1_q.image_end;
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && in_valid_i) s1_q <= in_data_i;
    if (adv2 && s1_v_q) s2_q <= s2_d;
  end

  always_comb begin
    band = 4'd0;
    for (int i = 0; i < 9; i++) begin
      if (s2_q.sum >= BandStep[i]) band = 4'(i + 1);
    end
  end

  assign cmd_valid_o     = s2_v_q;
  assign cmd_o.r         = split(s2_q.hr, s2_q.rr);
  assign cmd_o.g         = split(s2_q.hg, s2_q.rg);
  assign cmd_o.b         = split(s2_q.hb, s2_q.rb);
  assign cmd_o.glyph     = RampGlyph[band];
  assign cmd_o.row_end   = s2_q.row_end;
  assign cmd_o.image_end = s2_q.image_end;

endmodule
`default_nettype wire

// ----- sv/p2acg_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// p2acg_queue
// Short command queue that decouples classification from byte emission.
// ----------------------------------------------------------------------------
module p2acg_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire p2acg_pkg::cmd_t push_data_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 not_empty_o,
  output p2acg_pkg::cmd_t      head_o
);
  import p2acg_pkg::*;

  cmd_t            mem_q [QDepth];
  logic [QAw-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QAw:0]    count_q;
  logic            do_push, do_pop;

  assign full_o      = (count_q == (QAw+1)'(QDepth));
  assign not_empty_o = (count_q != '0);
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && not_empty_o;
  assign head_o      = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_push && !do_pop) count_q <= count_q + 1'b1;
      else if (do_pop && !do_push) count_q <= count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule
`default_nettype wire

// ----- sv/p2acg_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// p2acg_back
// Walks one command through the escape sequence, one byte per cycle while
// the output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module p2acg_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               q_not_empty_i,
  input  wire p2acg_pkg::cmd_t    q_head_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output p2acg_pkg::result_t      out_data_o
);
  import p2acg_pkg::*;

  function automatic step_e first_digit(input digits_t d, input step_e sh, input step_e st,
                                        input step_e so);
    step_e s;
    if (d.h != 2'd0) s = sh;
    else if (d.t != 4'd0) s = st;
    else s = so;
    return s;
  endfunction

  cmd_t    cmd_q;
  logic    cmd_v_q;
  step_e   step_q, step_nxt;
  result_t out_q;
  logic    out_v_q;
  logic    load, emit, last;
  logic [7:0] byte_val;

  assign load  = !out_v_q || !out_stall_i;
  assign emit  = load && cmd_v_q;
  assign pop_o = q_not_empty_i && (!cmd_v_q || (emit && last));

  always_comb begin
    step_nxt = ST_ESC;
    last     = 1'b0;
    byte_val = ChEsc;
    case (step_q)
      ST_ESC:    begin byte_val = ChEsc;   step_nxt = ST_LBR; end
      ST_LBR:    begin byte_val = ChLbr;   step_nxt = ST_3; end
      ST_3:      begin byte_val = ChThree; step_nxt = ST_8; end
      ST_8:      begin byte_val = ChEight; step_nxt = ST_SEMI_A; end
      ST_SEMI_A: begin byte_val = ChSemi;  step_nxt = ST_2; end
      ST_2:      begin byte_val = ChTwo;   step_nxt = ST_SEMI_B; end
      ST_SEMI_B: begin
        byte_val = ChSemi;
        step_nxt = first_digit(cmd_q.r, ST_RH, ST_RT, ST_RO);
      end
      ST_RH:     begin byte_val = ChZero + 8'(cmd_q.r.h); step_nxt = ST_RT; end
      ST_RT:     begin byte_val = ChZero + 8'(cmd_q.r.t); step_nxt = ST_RO; end
      ST_RO:     begin byte_val = ChZero + 8'(cmd_q.r.o); step_nxt = ST_SEMI_C; end
      ST_SEMI_C: begin
        byte_val = ChSemi;
        step_nxt = first_digit(cmd_q.g, ST_GH, ST_GT, ST_GO);
      end
      ST_GH:     begin byte_val = ChZero + 8'(cmd_q.g.h); step_nxt = ST_GT; end
      ST_GT:     begin byte_val = ChZero + 8'(cmd_q.g.t); step_nxt = ST_GO; end
      ST_GO:     begin byte_val = ChZero + 8'(cmd_q.g.o); step_nxt = ST_SEMI_D; end
      ST_SEMI_D: begin
        byte_val = ChSemi;
        step_nxt = first_digit(cmd_q.b, ST_BH, ST_BT, ST_BO);
      end
      ST_BH:     begin byte_val = ChZero + 8'(cmd_q.b.h); step_nxt = ST_BT; end
      ST_BT:     begin byte_val = ChZero + 8'(cmd_q.b.t); step_nxt = ST_BO; end
      ST_BO:     begin byte_val = ChZero + 8'(cmd_q.b.o); step_nxt = ST_M; end
      ST_M:      begin byte_val = ChM; step_nxt = ST_GLYPH; end
      ST_GLYPH:  begin
        byte_val = cmd_q.glyph;
        if (cmd_q.row_end) step_nxt = ST_NL;
        else if (cmd_q.image_end) step_nxt = ST_X0;
        else last = 1'b1;
      end
      ST_NL:     begin
        byte_val = ChNl;
        if (cmd_q.image_end) step_nxt = ST_X0;
        else last = 1'b1;
      end
      ST_X0:     begin byte_val = ChEsc;  step_nxt = ST_X1; end
      ST_X1:     begin byte_val = ChLbr;  step_nxt = ST_X2; end
      ST_X2:     begin byte_val = ChZero; step_nxt = ST_X3; end
      ST_X3:     begin byte_val = ChM;    last = 1'b1; end
      default:   begin byte_val = ChEsc;  last = 1'b1; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_v_q <= 1'b0;
      step_q  <= ST_ESC;
      out_v_q <= 1'b0;
    end else begin
      if (load) out_v_q <= cmd_v_q;
      if (pop_o) begin
        cmd_v_q <= 1'b1;
        step_q  <= ST_ESC;
      end else if (emit) begin
        cmd_v_q <= !last;
        step_q  <= step_nxt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) cmd_q <= q_head_i;
    if (emit) begin
      out_q.out_byte <= byte_val;
      out_q.run_last <= last;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  a_pop_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (!cmd_v_q || (emit && last)))
    else $error("command taken while one is still running");

  a_newline_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && step_q == ST_NL) |-> cmd_q.row_end)
    else $error("newline emitted without row end");

  a_reset_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && step_q == ST_X0) |-> cmd_q.image_end)
    else $error("colour reset emitted without image end");

  a_last_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && last) |=> (out_valid_o && out_data_o.run_last))
    else $error("final byte not presented with run_last");

endmodule
`default_nettype wire

// ----- sv/pixel_to_ansi_color_glyph_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_to_ansi_color_glyph_top
// Turns RGB pixels into ANSI truecolour escape text with a luminance glyph.
//
// Input channel: one pixel per item (in_valid_i / in_stall_o / in_data_i),
// with row_end and image_end flags.
// Output channel: one text byte per item (out_valid_o / out_stall_i /
// out_data_o), run_last marking the final byte of each pixel.
// Each pixel yields 14 to 25 bytes: ESC[38;2;R;G;Bm, the glyph, an optional
// newline and an optional ESC[0m.
// A pixel passes the two front-end stages, the command queue and the back
// end's command register before its first byte enters the output register.
// Throughput: one byte per cycle at the output register while the receiver
// does not stall; the back end takes the next pixel from the queue as it
// emits the last byte of the current one.
// The front end accepts a pixel per cycle until its two stages and the
// four-entry command queue fill.
// Reset empties the pipe, the queue and the output register.
// When the receiver stalls the output byte holds, and the queue and then
// the input channel back up.
// ----------------------------------------------------------------------------
module pixel_to_ansi_color_glyph_top (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire p2acg_pkg::pixel_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output p2acg_pkg::result_t      out_data_o
);
  import p2acg_pkg::*;

  cmd_t cmd, head;
  logic cmd_valid, q_full, q_not_empty, pop;

  p2acg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (cmd_valid),
    .q_full_i    (q_full),
    .cmd_o       (cmd)
  );

  p2acg_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (cmd_valid),
    .push_data_i (cmd),
    .full_o      (q_full),
    .pop_i       (pop),
    .not_empty_o (q_not_empty),
    .head_o      (head)
  );

  p2acg_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_not_empty_i (q_not_empty),
    .q_head_i      (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_data_o    (out_data_o)
  );

endmodule
`default_nettype wire
